FILE: hw/rtl/internet_checksum_pseudo_header_macros.svh
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef INTERNET_CHECKSUM_PSEUDO_HEADER_MACROS_SVH
`define INTERNET_CHECKSUM_PSEUDO_HEADER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ICPH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ICPH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/icph_pkg.sv
// ----------------------------------------------------------------------------
// icph_pkg
// Types and constants shared by the checksum block.
// ----------------------------------------------------------------------------
package icph_pkg;

    typedef logic [15:0] word_t;

    // Valid byte counts of one stream word; two and three count as a full word.
    localparam logic [1:0] BC_NONE = 2'd0;
    localparam logic [1:0] BC_LOW  = 2'd1;

    localparam word_t LOW_BYTE_MASK = 16'h00ff;

    typedef struct packed {
        logic        first_word;
        logic        last_word;
        logic [15:0] data_word;
        logic [1:0]  byte_count;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [7:0]  protocol;
        logic [15:0] length_field;
    } item_t;

endpackage

FILE: hw/rtl/icph_if.sv
// ----------------------------------------------------------------------------
// icph_if
// Valid/ready channels of the checksum block: packet words, result, config.
// ----------------------------------------------------------------------------
interface icph_pkt_if;
    logic        valid;
    logic        ready;
    logic        first_word;
    logic        last_word;
    logic [15:0] data_word;
    logic [1:0]  byte_count;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  protocol;
    logic [15:0] length_field;

    modport source (
        output valid, first_word, last_word, data_word, byte_count,
               source_address, dest_address, protocol, length_field,
        input  ready
    );
    modport sink (
        input  valid, first_word, last_word, data_word, byte_count,
               source_address, dest_address, protocol, length_field,
        output ready
    );
endinterface

interface icph_csum_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum_value;

    modport source (output valid, checksum_value, input ready);
    modport sink (input valid, checksum_value, output ready);
endinterface

interface icph_cfg_if;
    logic valid;
    logic ready;
    logic pseudo_header_enable;

    modport source (output valid, pseudo_header_enable, input ready);
    modport sink (input valid, pseudo_header_enable, output ready);
endinterface

FILE: hw/rtl/internet_checksum_pseudo_header.sv
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header
// Throughput: one word per cycle while no result stalls the pipeline; the
// running sum closes through a single 16-bit end-around-carry add in the
// accumulate stage.
// Reset clears the running sum, the pseudo-header enable and all valid flags.
// ----------------------------------------------------------------------------
module internet_checksum_pseudo_header (
    input  logic       clk,
    input  logic       rst_n,
    icph_pkt_if.sink   pkt,
    icph_csum_if.source csum,
    icph_cfg_if.sink   cfg
);

    logic            pseudo_reg;

    logic            s1_valid_reg;
    icph_pkg::item_t s1_item_reg;
    logic            s1_ready;

    logic            p_valid_reg;
    logic            p_first_reg;
    logic            p_last_reg;
    icph_pkg::word_t p_sum_reg;
    icph_pkg::word_t part;
    logic            p_ready;

    icph_pkg::word_t sum_reg;
    icph_pkg::word_t sum_next;
    icph_pkg::word_t acc_base;
    logic [16:0]     acc_wide;
    logic            acc_fire;

    logic            out_valid_reg;
    icph_pkg::word_t out_csum_reg;
    logic            out_free;

    icph_pkg::item_t pkt_item;

    assign pkt_item = '{
        first_word:     pkt.first_word,
        last_word:      pkt.last_word,
        data_word:      pkt.data_word,
        byte_count:     pkt.byte_count,
        source_address: pkt.source_address,
        dest_address:   pkt.dest_address,
        protocol:       pkt.protocol,
        length_field:   pkt.length_field
    };

    // Only a last word needs room in the result register.
    assign out_free = !out_valid_reg || csum.ready;
    assign acc_fire = p_valid_reg && (!p_last_reg || out_free);
    assign p_ready  = !p_valid_reg || acc_fire;
    assign s1_ready = !s1_valid_reg || p_ready;

    assign pkt.ready = s1_ready;
    assign cfg.ready = 1'b1;

    icph_hdr_sum u_hdr_sum (
        .item      (s1_item_reg),
        .pseudo_en (pseudo_reg),
        .part      (part)
    );

    assign acc_base = p_first_reg ? 16'h0000 : sum_reg;
    assign acc_wide = {1'b0, acc_base} + {1'b0, p_sum_reg};
    assign sum_next = acc_wide[15:0] + {15'd0, acc_wide[16]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pseudo_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            pseudo_reg <= cfg.pseudo_header_enable;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= pkt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && pkt.valid)
        begin
            s1_item_reg <= pkt_item;
        end
    end

    // Partial-sum register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (p_ready)
        begin
            p_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_ready && s1_valid_reg)
        begin
            p_first_reg <= s1_item_reg.first_word;
            p_last_reg  <= s1_item_reg.last_word;
            p_sum_reg   <= part;
        end
    end

    // Running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= 16'h0000;
        end
        else if (acc_fire)
        begin
            sum_reg <= sum_next;
        end
    end

    // Result register: load on a last word, drop after the transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (acc_fire && p_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (csum.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_fire && p_last_reg)
        begin
            out_csum_reg <= ~sum_next;
        end
    end

    assign csum.valid          = out_valid_reg;
    assign csum.checksum_value = out_csum_reg;

endmodule

FILE: hw/rtl/icph_hdr_sum.sv
// ----------------------------------------------------------------------------
// icph_hdr_sum
// Folded ones-complement sum of one word's own operands: pseudo-header
// terms on a first word when enabled, plus the word's valid bytes.
// ----------------------------------------------------------------------------
module icph_hdr_sum (
    input  icph_pkg::item_t item,
    input  logic            pseudo_en,
    output icph_pkg::word_t part
);

    logic            use_pseudo;
    icph_pkg::word_t src_lo;
    icph_pkg::word_t src_hi;
    icph_pkg::word_t dst_lo;
    icph_pkg::word_t dst_hi;
    icph_pkg::word_t proto_term;
    icph_pkg::word_t len_term;
    icph_pkg::word_t data_term;
    logic [18:0]     total;
    logic [16:0]     fold1;

    assign use_pseudo = item.first_word & pseudo_en;

    // Halves of the byte-swapped addresses.
    assign src_lo = use_pseudo ? {item.source_address[23:16], item.source_address[31:24]}
                               : 16'h0000;
    assign src_hi = use_pseudo ? {item.source_address[7:0], item.source_address[15:8]}
                               : 16'h0000;
    assign dst_lo = use_pseudo ? {item.dest_address[23:16], item.dest_address[31:24]}
                               : 16'h0000;
    assign dst_hi = use_pseudo ? {item.dest_address[7:0], item.dest_address[15:8]}
                               : 16'h0000;
    assign proto_term = use_pseudo ? {item.protocol, 8'h00} : 16'h0000;
    assign len_term   = use_pseudo ? item.length_field : 16'h0000;

    always_comb
    begin
        case (item.byte_count)
            icph_pkg::BC_NONE: data_term = 16'h0000;
            icph_pkg::BC_LOW:  data_term = item.data_word & icph_pkg::LOW_BYTE_MASK;
            default:           data_term = item.data_word;
        endcase
    end

    // Wide sum, then end-around carry; a zero sum stays zero.
    assign total = {3'b000, src_lo} + {3'b000, src_hi} + {3'b000, dst_lo}
                 + {3'b000, dst_hi} + {3'b000, proto_term} + {3'b000, len_term}
                 + {3'b000, data_term};
    assign fold1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
    assign part  = fold1[15:0] + {15'd0, fold1[16]};

endmodule

FILE: hw/rtl/icph_checker.sv
// ----------------------------------------------------------------------------
// icph_checker
// Port-level checks of the checksum block, bound to the top level.
// ----------------------------------------------------------------------------
`include "internet_checksum_pseudo_header_macros.svh"

module icph_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pkt_ready,
    input logic        csum_valid,
    input logic        csum_ready,
    input logic [15:0] csum_value,
    input logic        cfg_ready
);

    // Hold a stalled result.
    `ICPH_ASSERT_NEXT(a_csum_hold, clk, rst_n, csum_valid && !csum_ready, csum_valid && $stable(csum_value), "stalled checksum changed")

    // Drop a result only after its transfer.
    `ICPH_ASSERT_NOW(a_csum_drop, clk, rst_n, $fell(csum_valid), $past(csum_ready), "checksum dropped without transfer")

    // Back-pressure on packet words comes only from a stalled result.
    `ICPH_ASSERT_NOW(a_pkt_stall, clk, rst_n, !pkt_ready, csum_valid && !csum_ready, "word input stalled without a waiting result")

    // Configuration writes are always taken.
    `ICPH_ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready, "configuration write refused")

endmodule

bind internet_checksum_pseudo_header icph_checker u_icph_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pkt_ready  (pkt.ready),
    .csum_valid (csum.valid),
    .csum_ready (csum.ready),
    .csum_value (csum.checksum_value),
    .cfg_ready  (cfg.ready)
);
